// ===== rtl/qftu_pkg.sv =====
// Package with payload types, register indexes and constants for the token unpack core.
package qftu_pkg;

   localparam int unsigned LANES = 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_COMMON_EXPONENT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOKEN_SHIFT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MINIMUM_MANTISSA = 2'd2;

   localparam logic [23:0] MAG_LIMIT = 24'hFFFFFF;

   typedef struct packed {
      logic [31:0] packed_word;
      logic        second_present;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] first_value;
      logic [31:0] second_value;
      logic        second_valid;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]  common_exponent;
      logic [4:0]  token_shift;
      logic [31:0] minimum_mantissa;
   } csr_type;

   // Stage one result of a lane: sign and saturated magnitude.
   typedef struct packed {
      logic        sign;
      logic [23:0] mag;
   } lane_mid_type;

endpackage

// ===== rtl/qftu_lane_front.sv =====
// Lane front half: shift, offset add, absolute value and saturation of one token.
module qftu_lane_front
   import qftu_pkg::*;
(
   input  logic [15:0]  token,
   input  csr_type      csr,
   output lane_mid_type mid
);
   logic [31:0] sum;
   logic [31:0] absval;

   always_comb begin
      sum = ({16'd0, token} << csr.token_shift) + csr.minimum_mantissa;
      absval = sum[31] ? (32'd0 - sum) : sum;
      mid.sign = sum[31];
      mid.mag = (absval > {8'd0, MAG_LIMIT}) ? MAG_LIMIT : absval[23:0];
   end
endmodule

// ===== rtl/qftu_lane_back.sv =====
// Lane back half: builds the IEEE single pattern from sign, magnitude and exponent.
module qftu_lane_back
   import qftu_pkg::*;
(
   input  lane_mid_type mid,
   input  logic [7:0]   exponent,
   output logic [31:0]  value
);
   logic [22:0] low;
   logic [4:0]  p;
   logic [9:0]  be;
   logic [22:0] norm;

   always_comb begin
      low = mid.mag[22:0];
      p = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (low[i]) p = 5'(i);
      end
      be = 10'({5'd0, p}) + {2'd0, exponent} - 10'd23;
      norm = low << (5'd23 - p);
      if (exponent == 8'd0) begin
         value = 32'd0;
      end else if (mid.mag[23]) begin
         value = {mid.sign, exponent, low};
      end else if (low == 23'd0) begin
         value = 32'd0;
      end else if (!be[9] && be != 10'd0) begin
         value = {mid.sign, be[7:0], norm};
      end else begin
         value = {mid.sign, 8'd0, 23'(low << (exponent - 8'd1))};
      end
   end
endmodule

// ===== rtl/quantized_float_token_unpack_core.sv =====
// Top level of the two-lane quantized float token unpack core.
// The req channel carries one 32-bit word with two 16-bit tokens per transaction;
// the upper token is decoded into first_value and the lower into second_value.
// Each token runs through its own lane: an add-and-saturate front half, then a
// pipeline register, then a normalize and pack back half whose result is merged
// into the rsp output register.
// A transaction accepted on req is registered first in the lane pipeline
// register and then in the rsp output register, which drives rsp_valid; the
// two-stage lane pipeline takes one transaction per cycle while rsp is not stalled.
// A stall on rsp holds the pipeline; a stage takes a new transaction whenever
// it is empty or the stage after it moves, so req keeps flowing while
// any stage has room.
// The csr port writes one of common_exponent, token_shift and minimum_mantissa
// per write, chosen by csr_index; write only while no transaction is in flight.
// Synchronous reset empties the pipeline and clears the csr registers to zero.
module quantized_float_token_unpack_core
   import qftu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   csr_type         csr_ff;
   lane_mid_type    mid_in [LANES];
   lane_mid_type    mid_ff [LANES];
   logic            present_ff;
   logic            s1_valid_ff;
   logic            out_valid_ff;
   rsp_payload_type out_ff;
   logic [31:0]     value [LANES];
   logic            adv_out;
   logic            adv_s1;

   assign adv_out = !out_valid_ff || !rsp_stall;
   assign adv_s1 = !s1_valid_ff || adv_out;
   assign req_stall = !adv_s1;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      qftu_lane_front u_front (
         .token (req_payload.packed_word[16*(LANES-1-g) +: 16]),
         .csr   (csr_ff),
         .mid   (mid_in[g])
      );
      qftu_lane_back u_back (
         .mid      (mid_ff[g]),
         .exponent (csr_ff.common_exponent),
         .value    (value[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_COMMON_EXPONENT:  csr_ff.common_exponent <= csr_data[7:0];
               CSR_TOKEN_SHIFT:      csr_ff.token_shift <= csr_data[4:0];
               CSR_MINIMUM_MANTISSA: csr_ff.minimum_mantissa <= csr_data;
               default: ;
            endcase
         end
         if (adv_s1) s1_valid_ff <= req_valid;
         if (adv_out) out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_s1) begin
         mid_ff <= mid_in;
         present_ff <= req_payload.second_present;
      end
      if (adv_out) begin
         out_ff.first_value <= value[0];
         out_ff.second_value <= present_ff ? value[1] : 32'd0;
         out_ff.second_valid <= present_ff;
      end
   end

`ifndef NO_ASSERTIONS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp changed under stall");
   a_absent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.second_valid |-> rsp_payload.second_value == 32'd0)
      else $error("absent second value not zero");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_stall |=> rsp_valid)
      else $error("stage one transaction lost");
`endif
endmodule
